// ----- hw/rtl/prtt_pkg.sv -----
// shared types and constants for the per-peer trip time statistics unit
`timescale 1ns / 1ps
package prtt_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned CmdW  = 3;
  localparam int unsigned PeerW = 4;

  localparam logic [CmdW-1:0] CMD_CLEAR   = 3'd0;
  localparam logic [CmdW-1:0] CMD_ACK     = 3'd1;
  localparam logic [CmdW-1:0] CMD_SENT    = 3'd2;
  localparam logic [CmdW-1:0] CMD_RECV    = 3'd3;
  localparam logic [CmdW-1:0] CMD_DROP    = 3'd4;
  localparam logic [CmdW-1:0] CMD_RETRY   = 3'd5;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [PeerW-1:0] peer;
    logic [WordW-1:0] now_time;
    logic [WordW-1:0] sent_time;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0] trip_last;
    logic [WordW-1:0] trip_mean;
    logic [WordW-1:0] trip_min;
    logic [WordW-1:0] trip_max;
    logic [WordW-1:0] recent_max;
    logic [WordW-1:0] ack_count;
    logic [WordW-1:0] sent_count;
    logic [WordW-1:0] received_count;
    logic [WordW-1:0] dropped_count;
    logic [WordW-1:0] retry_count;
  } out_item_t;

endpackage

// ----- hw/rtl/per_peer_link_rtt_statistics_unit.sv -----
// top level of the per-peer trip time statistics unit
`timescale 1ns / 1ps
// One request at a time: busy rises on the cycle after start and falls when the
// result strobe fires. An ack runs the 64-step mean divider and then a
// one-entry-per-cycle scan of the window memory; a clear zeroes the peer's window
// entries. Results appear for one cycle on out_valid and cannot be held off. After
// reset a clearing pass over all PEERS * WINDOW window entries and every record
// runs with busy high. A peer index at or above PEERS returns an all-zero record.
module per_peer_link_rtt_statistics_unit #(
  parameter int unsigned PEERS  = 16,
  parameter int unsigned WINDOW = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  prtt_pkg::in_item_t   in_item,
  output logic                 out_valid,
  output prtt_pkg::out_item_t  out_item
);

  localparam int unsigned PW  = (PEERS  > 1) ? $clog2(PEERS)  : 1;
  localparam int unsigned WW  = $clog2(WINDOW + 1);
  localparam int unsigned WD  = PEERS * WINDOW;
  localparam int unsigned WAW = (WD > 1) ? $clog2(WD) : 1;
  localparam int unsigned CW  = $clog2(WD + 1);

  typedef enum logic [8:0] {
    S_INIT  = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_READ  = 9'b000000100,
    S_CALC  = 9'b000001000,
    S_DIV   = 9'b000010000,
    S_SCAN  = 9'b000100000,
    S_SWAIT = 9'b001000000,
    S_WB    = 9'b010000000,
    S_CLR   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // record memory, one wide word per peer
  prtt_pkg::out_item_t rec_mem [PEERS];
  prtt_pkg::out_item_t rec_rd_r;
  logic [WW-1:0] widx_mem [PEERS];
  logic [WW-1:0] widx_rd_r;
  logic [31:0] win_mem [WD];
  logic [31:0] win_rd_r;

  logic          rec_we;
  logic [PW-1:0] rec_addr;
  prtt_pkg::out_item_t rec_wd;
  logic          win_we;
  logic [WAW-1:0] win_waddr, win_raddr;
  logic [31:0]   win_wd;

  prtt_pkg::in_item_t req_r;
  prtt_pkg::out_item_t rec_r, rec_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [31:0] max_r, max_nxt;
  logic [63:0] prod_r;
  logic [31:0] last_r;
  logic [WW-1:0] idx_r;
  logic          in_range_r;
  logic          ov_r, ov_nxt;
  prtt_pkg::out_item_t ov_item_r, ov_item_nxt;
  logic [PW-1:0] peer_idx;
  logic [WAW-1:0] win_base;
  logic [63:0] dividend;
  logic        div_start;
  logic        div_done;
  logic [31:0] div_q;
  logic        req_fire;

  assign peer_idx  = req_r.peer[PW-1:0];
  assign win_base  = WAW'(peer_idx * WINDOW);
  assign req_fire  = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign dividend  = prod_r + {32'd0, last_r};

  prtt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  ({1'b0, rec_r.ack_count} + 33'd1),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    prtt_pkg::out_item_t clr;
    clr = '0;
    clr.trip_min = '1;
    state_nxt   = state_r;
    rec_nxt     = rec_r;
    cnt_nxt     = cnt_r;
    max_nxt     = max_r;
    ov_nxt      = 1'b0;
    ov_item_nxt = ov_item_r;
    rec_we      = 1'b0;
    rec_addr    = peer_idx;
    rec_wd      = rec_r;
    win_we      = 1'b0;
    win_waddr   = win_base + WAW'(cnt_r);
    win_raddr   = win_base + WAW'(cnt_r);
    win_wd      = '0;
    div_start   = 1'b0;
    case (state_r)
      S_INIT: begin
        // clear all records and window entries
        win_we    = 1'b1;
        win_waddr = WAW'(cnt_r);
        rec_we    = (cnt_r < CW'(PEERS));
        rec_addr  = PW'(cnt_r);
        rec_wd    = clr;
        cnt_nxt   = cnt_r + CW'(1);
        if (cnt_r == CW'(WD - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_fire) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (!in_range_r) begin
          ov_nxt      = 1'b1;
          ov_item_nxt = '0;
          state_nxt   = S_IDLE;
        end else begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        rec_nxt = rec_rd_r;
        cnt_nxt = '0;
        case (req_r.cmd)
          prtt_pkg::CMD_CLEAR: begin
            rec_nxt   = clr;
            state_nxt = S_CLR;
          end
          prtt_pkg::CMD_ACK:   state_nxt = S_DIV;
          prtt_pkg::CMD_SENT: begin
            rec_nxt.sent_count = rec_rd_r.sent_count + 32'd1;
            state_nxt = S_WB;
          end
          prtt_pkg::CMD_RECV: begin
            rec_nxt.received_count = rec_rd_r.received_count + 32'd1;
            state_nxt = S_WB;
          end
          prtt_pkg::CMD_DROP: begin
            rec_nxt.dropped_count = rec_rd_r.dropped_count + 32'd1;
            state_nxt = S_WB;
          end
          prtt_pkg::CMD_RETRY: begin
            rec_nxt.retry_count = rec_rd_r.retry_count + 32'd1;
            state_nxt = S_WB;
          end
          default: state_nxt = S_WB;
        endcase
      end
      S_DIV: begin
        // first cycle: product registered already; launch divider once and write the trip into the window
        if (cnt_r == '0) begin
          div_start = 1'b1;
          cnt_nxt = CW'(1);
          win_we    = 1'b1;
          win_waddr = win_base + WAW'(idx_r);
          win_wd    = last_r;
        end else if (div_done) begin
          rec_nxt.trip_mean = div_q;
          rec_nxt.trip_last = last_r;
          rec_nxt.ack_count = rec_r.ack_count + 32'd1;
          if (last_r < rec_r.trip_min) rec_nxt.trip_min = last_r;
          if (last_r > rec_r.trip_max) rec_nxt.trip_max = last_r;
          cnt_nxt   = '0;
          max_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // issue the first window read; the registered data returns in the next cycle
        cnt_nxt   = cnt_r + CW'(1);
        state_nxt = S_SWAIT;
      end
      S_SWAIT: begin
        if (win_rd_r > max_r) max_nxt = win_rd_r;
        if (cnt_r == CW'(WINDOW)) begin
          rec_nxt.recent_max = (win_rd_r > max_r) ? win_rd_r : max_r;
          state_nxt = S_WB;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      S_CLR: begin
        win_we    = 1'b1;
        win_waddr = win_base + WAW'(cnt_r);
        cnt_nxt   = cnt_r + CW'(1);
        if (cnt_r == CW'(WINDOW - 1)) begin
          state_nxt = S_WB;
          rec_nxt   = clr;
        end
      end
      S_WB: begin
        rec_we      = 1'b1;
        ov_nxt      = 1'b1;
        ov_item_nxt = rec_r;
        state_nxt   = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_SWAIT) begin
      win_raddr = win_base + WAW'(cnt_r);
    end
  end

  // window index update
  logic [WW-1:0] idx_nxt;
  always_comb begin
    idx_nxt = idx_r;
    if (state_r == S_CALC) begin
      idx_nxt = (widx_rd_r >= WW'(WINDOW)) ? '0 : widx_rd_r;
    end else if (state_r == S_SWAIT && cnt_r == CW'(WINDOW)) begin
      idx_nxt = (idx_r == WW'(WINDOW - 1)) ? '0 : idx_r + WW'(1);
    end else if (state_r == S_CLR) begin
      idx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[rec_addr]  <= rec_wd;
      widx_mem[rec_addr] <= (state_r == S_INIT) ? '0 : idx_r;
    end
    rec_rd_r  <= rec_mem[peer_idx];
    widx_rd_r <= widx_mem[peer_idx];
    if (win_we) begin
      win_mem[win_waddr] <= win_wd;
    end
    win_rd_r <= win_mem[win_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
    rec_r     <= rec_nxt;
    max_r     <= max_nxt;
    ov_item_r <= ov_item_nxt;
    idx_r     <= idx_nxt;
    if (req_fire) begin
      req_r      <= in_item;
      in_range_r <= ({28'd0, in_item.peer} < 32'(PEERS));
    end
    if (state_r == S_CALC) begin
      last_r <= req_r.now_time - req_r.sent_time;
      prod_r <= {32'd0, rec_rd_r.ack_count} * {32'd0, rec_rd_r.trip_mean};
    end
  end

  assign out_valid = ov_r;
  assign out_item  = ov_item_r;

endmodule

// ----- hw/rtl/prtt_div.sv -----
// restoring divider, 64-bit dividend by 33-bit divisor, one quotient bit per cycle
`timescale 1ns / 1ps
module prtt_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [32:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic [63:0] quo_r, quo_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [32:0] den_r, den_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [33:0] trial;
  logic [33:0] shifted;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[32:0], quo_r[63]};
    trial    = shifted - {1'b0, den_r};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
      cnt_nxt  = 7'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[33]) begin
        rem_nxt = trial;
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r[31:0];

endmodule

// ----- hw/rtl/prtt_checker.sv -----
// port-level checks for the per-peer trip time statistics unit
`timescale 1ns / 1ps
module prtt_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input prtt_pkg::out_item_t out_item
);

  // a request makes the unit busy on the next cycle
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy did not rise after request");

  // results only while a request is in flight
  a_valid_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without request");

  // strobe is a single pulse
  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  // min never above max once an ack was seen
  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.ack_count != 32'd0 |-> out_item.trip_min <= out_item.trip_max)
    else $error("minimum above maximum");

endmodule

bind per_peer_link_rtt_statistics_unit prtt_checker u_prtt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

// ----- verif/tb_per_peer_link_rtt_statistics_unit.sv -----
// self-checking testbench for the per-peer trip time statistics unit
`timescale 1ns / 1ps
module tb_per_peer_link_rtt_statistics_unit;

  localparam int unsigned NumPeers = 16;
  localparam int unsigned WinDepth = 10;
  localparam int unsigned StallLimit = 5000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  prtt_pkg::in_item_t in_item;
  logic out_valid;
  prtt_pkg::out_item_t out_item;

  per_peer_link_rtt_statistics_unit #(
    .PEERS(NumPeers),
    .WINDOW(WinDepth)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_item(out_item)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // shadow copy of every peer record
  logic [31:0] sh_last [NumPeers];
  logic [31:0] sh_mean [NumPeers];
  logic [31:0] sh_min [NumPeers];
  logic [31:0] sh_max [NumPeers];
  logic [31:0] sh_rmax [NumPeers];
  logic [31:0] sh_acks [NumPeers];
  logic [31:0] sh_sent [NumPeers];
  logic [31:0] sh_recv [NumPeers];
  logic [31:0] sh_drop [NumPeers];
  logic [31:0] sh_retry [NumPeers];
  logic [31:0] sh_win [NumPeers][WinDepth];
  int unsigned sh_widx [NumPeers];

  prtt_pkg::out_item_t expected_records[$];
  int unsigned mismatch_count;
  int unsigned sender_idle_pct;
  int unsigned quiet_cycles;

  function automatic void clear_shadow(int unsigned p);
    sh_last[p] = '0;
    sh_mean[p] = '0;
    sh_min[p] = '1;
    sh_max[p] = '0;
    sh_rmax[p] = '0;
    sh_acks[p] = '0;
    sh_sent[p] = '0;
    sh_recv[p] = '0;
    sh_drop[p] = '0;
    sh_retry[p] = '0;
    for (int i = 0; i < WinDepth; i++) sh_win[p][i] = '0;
    sh_widx[p] = 0;
  endfunction

  function automatic prtt_pkg::out_item_t predict_record(prtt_pkg::in_item_t it);
    int unsigned p;
    logic [31:0] trip;
    logic [63:0] num;
    logic [63:0] den;
    logic [31:0] m;
    prtt_pkg::out_item_t r;
    p = it.peer;
    case (it.cmd)
      prtt_pkg::CMD_CLEAR: clear_shadow(p);
      prtt_pkg::CMD_ACK: begin
        trip = it.now_time - it.sent_time;
        num = 64'(sh_acks[p]) * 64'(sh_mean[p]) + 64'(trip);
        den = 64'(sh_acks[p]) + 64'd1;
        sh_last[p] = trip;
        sh_mean[p] = 32'(num / den);
        sh_acks[p] = sh_acks[p] + 32'd1;
        if (trip < sh_min[p]) sh_min[p] = trip;
        if (trip > sh_max[p]) sh_max[p] = trip;
        sh_win[p][sh_widx[p]] = trip;
        sh_widx[p] = (sh_widx[p] == WinDepth - 1) ? 0 : sh_widx[p] + 1;
        m = '0;
        for (int i = 0; i < WinDepth; i++) if (sh_win[p][i] > m) m = sh_win[p][i];
        sh_rmax[p] = m;
      end
      prtt_pkg::CMD_SENT: sh_sent[p] = sh_sent[p] + 32'd1;
      prtt_pkg::CMD_RECV: sh_recv[p] = sh_recv[p] + 32'd1;
      prtt_pkg::CMD_DROP: sh_drop[p] = sh_drop[p] + 32'd1;
      prtt_pkg::CMD_RETRY: sh_retry[p] = sh_retry[p] + 32'd1;
      default: ;
    endcase
    r.trip_last = sh_last[p];
    r.trip_mean = sh_mean[p];
    r.trip_min = sh_min[p];
    r.trip_max = sh_max[p];
    r.recent_max = sh_rmax[p];
    r.ack_count = sh_acks[p];
    r.sent_count = sh_sent[p];
    r.received_count = sh_recv[p];
    r.dropped_count = sh_drop[p];
    r.retry_count = sh_retry[p];
    return r;
  endfunction

  task automatic send_request(logic [prtt_pkg::CmdW-1:0] cmd,
                              logic [prtt_pkg::PeerW-1:0] peer,
                              logic [31:0] now_t, logic [31:0] sent_t);
    prtt_pkg::in_item_t it;
    int unsigned gap;
    it.cmd = cmd;
    it.peer = peer;
    it.now_time = now_t;
    it.sent_time = sent_t;
    gap = 0;
    while ($urandom_range(0, 99) < sender_idle_pct && gap < 200) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    expected_records.push_back(predict_record(it));
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch %s: expected %h actual %h", name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    prtt_pkg::out_item_t e;
    if (rst_n && out_valid) begin
      if (expected_records.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %h", out_item);
      end else begin
        e = expected_records.pop_front();
        check_field("trip_last", e.trip_last, out_item.trip_last);
        check_field("trip_mean", e.trip_mean, out_item.trip_mean);
        check_field("trip_min", e.trip_min, out_item.trip_min);
        check_field("trip_max", e.trip_max, out_item.trip_max);
        check_field("recent_max", e.recent_max, out_item.recent_max);
        check_field("ack_count", e.ack_count, out_item.ack_count);
        check_field("sent_count", e.sent_count, out_item.sent_count);
        check_field("received_count", e.received_count, out_item.received_count);
        check_field("dropped_count", e.dropped_count, out_item.dropped_count);
        check_field("retry_count", e.retry_count, out_item.retry_count);
      end
    end
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("tb_per_peer_link_rtt_statistics_unit failed");
      $finish;
    end
  end

  task automatic test_counters();
    for (int c = prtt_pkg::CMD_SENT; c <= prtt_pkg::CMD_RETRY; c++) begin
      send_request(c[prtt_pkg::CmdW-1:0], 4'd0, '0, '0);
      send_request(c[prtt_pkg::CmdW-1:0], 4'd15, '1, '1);
    end
    send_request(3'd6, 4'd0, '0, '0);
    send_request(3'd7, 4'd15, '1, '0);
  endtask

  task automatic test_ack_extremes();
    send_request(prtt_pkg::CMD_ACK, 4'd1, 32'd100, 32'd100);
    send_request(prtt_pkg::CMD_ACK, 4'd1, 32'd0, 32'd1);
    send_request(prtt_pkg::CMD_ACK, 4'd1, 32'd5, 32'hffff_fff0);
    send_request(prtt_pkg::CMD_ACK, 4'd15, '1, '0);
    // more acks on one peer than the window holds, so its oldest trip times age out
    for (int i = 0; i < 12; i++) send_request(prtt_pkg::CMD_ACK, 4'd2, 32'd50 + i, 32'd0);
    send_request(prtt_pkg::CMD_CLEAR, 4'd1, '0, '0);
    send_request(prtt_pkg::CMD_CLEAR, 4'd15, '1, '1);
  endtask

  task automatic test_random(int unsigned n_items, int unsigned idle_pct);
    int unsigned sel;
    logic [31:0] sent_t;
    logic [31:0] now_t;
    logic [prtt_pkg::CmdW-1:0] cmd;
    sender_idle_pct = idle_pct;
    for (int n = 0; n < n_items; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 3) cmd = prtt_pkg::CMD_CLEAR;
      else if (sel < 55) cmd = prtt_pkg::CMD_ACK;
      else if (sel < 66) cmd = prtt_pkg::CMD_SENT;
      else if (sel < 77) cmd = prtt_pkg::CMD_RECV;
      else if (sel < 87) cmd = prtt_pkg::CMD_DROP;
      else if (sel < 97) cmd = prtt_pkg::CMD_RETRY;
      else cmd = 3'($urandom_range(6, 7));
      sent_t = $urandom;
      now_t = ($urandom_range(0, 3) == 0) ? $urandom : sent_t + $urandom_range(0, 5000);
      send_request(cmd, 4'($urandom_range(0, NumPeers - 1)), now_t, sent_t);
    end
  endtask

  initial begin
    mismatch_count = 0;
    sender_idle_pct = 0;
    quiet_cycles = 0;
    for (int p = 0; p < NumPeers; p++) clear_shadow(p);
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_counters();
    test_ack_extremes();
    test_random(350, 0);
    test_random(350, 88);
    test_random(350, 26);
    start <= 1'b0;
    while (expected_records.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) $display("tb_per_peer_link_rtt_statistics_unit passed");
    else $display("tb_per_peer_link_rtt_statistics_unit failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/prtt_pkg.sv
hw/rtl/prtt_div.sv
hw/rtl/per_peer_link_rtt_statistics_unit.sv
hw/rtl/prtt_checker.sv
verif/tb_per_peer_link_rtt_statistics_unit.sv
